// ----- src/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// shared types and constants of the byte ring fifo with pattern seek
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DEPTH_DEF    = 4096;
    localparam int MAX_XFER_DEF = 8;

    // payload field widths
    localparam int OP_W     = 3;
    localparam int COUNT_W  = 4;
    localparam int WORD_W   = 64;
    localparam int SKIP_W   = 13;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 12;
    localparam int MOVED_W  = 13;
    localparam int FILL_W   = 13;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_SEEK    = 3'd3,
        OP_DISCARD = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NO_DATA  = 2'd2
    } status_t;

    // control from the sequencer to the pattern compare unit
    typedef struct packed {
        logic               load;
        logic               shift;
        logic [COUNT_W-1:0] len;
        logic [7:0]         in_byte;
    } match_ctrl_t;

endpackage

// ----- src/brf_if.sv -----
// ----------------------------------------------------------------------------
// brf_req_if / brf_rsp_if
// request and result channels of the byte ring fifo
// ----------------------------------------------------------------------------
interface brf_req_if
    import brf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [COUNT_W-1:0]  byte_count;
    logic [WORD_W-1:0]   data_word;
    logic [SKIP_W-1:0]   skip_count;

    modport source (output valid, operation, byte_count, data_word, skip_count,
                    input ready);
    modport sink (input valid, operation, byte_count, data_word, skip_count,
                  output ready);
endinterface

interface brf_rsp_if
    import brf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   read_word;
    logic [OFFSET_W-1:0] match_offset;
    logic [MOVED_W-1:0]  moved_count;
    logic [FILL_W-1:0]   fill_level;

    modport source (output valid, status, read_word, match_offset, moved_count,
                    fill_level, input ready);
    modport sink (input valid, status, read_word, match_offset, moved_count,
                  fill_level, output ready);
endinterface

// ----- src/brf_match.sv -----
// ----------------------------------------------------------------------------
// brf_match
// sliding byte window and masked pattern compare used by seek
// ----------------------------------------------------------------------------
module brf_match
    import brf_pkg::*;
#(
    parameter int MAX_XFER = MAX_XFER_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  match_ctrl_t       ctrl,
    input  logic [WORD_W-1:0] pattern,
    output logic              hit
);
    localparam int W = 8 * MAX_XFER;

    logic [W-1:0]       win_reg;
    logic [W-1:0]       pat_reg;
    logic [W-1:0]       mask_reg;
    logic [W-1:0]       win_shifted;
    logic [COUNT_W-1:0] gap;

    // newest byte enters at the top, so the last len bytes sit in the upper octets
    assign win_shifted = (win_reg >> 8) | (W'(ctrl.in_byte) << (W - 8));
    assign gap         = COUNT_W'(MAX_XFER) - ctrl.len;
    assign hit         = ((win_shifted & mask_reg) == pat_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            pat_reg  <= '0;
            mask_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                pat_reg  <= pattern[W-1:0] << {gap, 3'b000};
                mask_reg <= {W{1'b1}} << {gap, 3'b000};
            end
            if (ctrl.shift)
            begin
                win_reg <= win_shifted;
            end
        end
    end

endmodule

// ----- src/byte_ring_fifo_with_pattern_seek.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_pattern_seek
// byte-wide circular fifo with push, pop, peek, seek, discard and clear
// ----------------------------------------------------------------------------
// usage
//   request channel carries one operation per request: push stores up to
//   MAX_XFER bytes, pop and peek read up to MAX_XFER bytes from the head,
//   seek looks for a pattern of up to MAX_XFER bytes, discard drops bytes at
//   the head, clear empties the fifo. every request yields exactly one result
//   on the result channel, carrying status, read data, match offset, moved
//   byte count and the fill level after the operation.
//   the store is a single byte-wide memory with one write and one registered
//   read per cycle, so each request walks it one byte a cycle: push writes
//   its n bytes, pop and peek read n bytes, seek reads at most every stored
//   byte and stops at the first match, while discard, clear and a rejected
//   request take no byte step. the result is registered from the finish
//   step once the result register is free.
//   request ready is high only while the sequencer is idle; it does not wait
//   for the result register, so a new request is taken while an earlier
//   result is still held. if the receiver stalls, a finished request waits in
//   its last step until the result register frees up.
//   reset empties the fifo (head, tail and fill level to zero); stored bytes
//   are never read before they were written, so the memory is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_pattern_seek
    import brf_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int MAX_XFER = MAX_XFER_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    brf_req_if.sink   request,
    brf_rsp_if.source result
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int SUM_W = OCC_W + 1;
    localparam int SK_W  = (OCC_W > SKIP_W) ? OCC_W : SKIP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_READ,
        S_FINISH
    } state_t;

    // byte store
    logic [7:0] ring_mem [DEPTH];
    logic [7:0] q_reg;

    // sequencer and fifo pointers
    state_t             state_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   tail_reg;
    logic [OCC_W-1:0]   occ_reg;
    op_t                op_reg;
    logic [COUNT_W-1:0] len_reg;
    logic [WORD_W-1:0]  data_reg;
    logic [OCC_W-1:0]   total_reg;
    logic [OCC_W-1:0]   iss_reg;
    logic [OCC_W-1:0]   pos_reg;
    logic               dvalid_reg;
    logic [IDX_W-1:0]   rd_addr_reg;

    // pending result
    status_t             res_status_reg;
    logic [WORD_W-1:0]   res_word_reg;
    logic [OFFSET_W-1:0] res_offset_reg;
    logic [MOVED_W-1:0]  res_moved_reg;

    // result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [WORD_W-1:0]   out_word_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic [MOVED_W-1:0]  out_moved_reg;
    logic [FILL_W-1:0]   out_fill_reg;

    logic               accept;
    op_t                op_in;
    logic [COUNT_W-1:0] n_in;
    logic [OCC_W-1:0]   n_ext;
    logic [OCC_W-1:0]   free_space;
    logic               skip_ok;
    logic [SUM_W-1:0]   skip_sum;
    logic [SUM_W-1:0]   skip_head;
    logic               issue;
    logic [OCC_W-1:0]   pos_inc;
    logic               out_free;
    logic               mem_we;
    match_ctrl_t        mctrl;
    logic               hit;

    // decode of the incoming request: first step, status and moved count
    state_t             start_state;
    status_t            start_status;
    logic [MOVED_W-1:0] start_moved;

    assign accept     = request.valid && request.ready;
    assign op_in      = op_t'(request.operation);
    assign n_in       = (request.byte_count > COUNT_W'(MAX_XFER)) ?
                        COUNT_W'(MAX_XFER) : request.byte_count;
    assign n_ext      = OCC_W'(n_in);
    assign free_space = OCC_W'(DEPTH) - occ_reg;

    // discard: skip never exceeds the fill level, so one wrap is enough
    assign skip_ok   = SK_W'(request.skip_count) <= SK_W'(occ_reg);
    assign skip_sum  = SUM_W'(head_reg) + SUM_W'(OCC_W'(request.skip_count));
    assign skip_head = (skip_sum >= SUM_W'(DEPTH)) ? (skip_sum - SUM_W'(DEPTH)) : skip_sum;

    // one read issued per cycle until all bytes of the request are requested
    assign issue   = (state_reg == S_READ) && (iss_reg != total_reg);
    assign pos_inc = pos_reg + 1'b1;
    assign out_free = !out_valid_reg || result.ready;
    assign mem_we  = (state_reg == S_PUSH);

    assign request.ready       = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.read_word    = out_word_reg;
    assign result.match_offset = out_offset_reg;
    assign result.moved_count  = out_moved_reg;
    assign result.fill_level   = out_fill_reg;

    // pattern compare unit, fed one stored byte per cycle
    assign mctrl.load    = accept && (op_in == OP_SEEK);
    assign mctrl.shift   = (state_reg == S_READ) && dvalid_reg && (op_reg == OP_SEEK);
    assign mctrl.len     = n_in;
    assign mctrl.in_byte = q_reg;

    brf_match #(
        .MAX_XFER (MAX_XFER)
    ) u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mctrl),
        .pattern (request.data_word),
        .hit     (hit)
    );

    // checks of the incoming request against the current fill level
    always_comb
    begin
        start_state  = S_FINISH;
        start_status = ST_DONE;
        start_moved  = '0;
        case (op_in)
            OP_PUSH:
            begin
                if (n_ext > free_space)
                begin
                    start_status = ST_NO_SPACE;
                end
                else if (n_in != '0)
                begin
                    start_moved = MOVED_W'(n_in);
                    start_state = S_PUSH;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (n_ext > occ_reg)
                begin
                    start_status = ST_NO_DATA;
                end
                else if (n_in != '0)
                begin
                    start_moved = MOVED_W'(n_in);
                    start_state = S_READ;
                end
            end
            OP_SEEK:
            begin
                // empty pattern matches at the head
                if (n_in != '0)
                begin
                    start_status = ST_NO_DATA;
                    if (n_ext <= occ_reg)
                    begin
                        start_state = S_READ;
                    end
                end
            end
            OP_DISCARD:
            begin
                if (!skip_ok)
                begin
                    start_status = ST_NO_DATA;
                end
                else
                begin
                    start_moved = MOVED_W'(request.skip_count);
                end
            end
            default:
            begin
                // clear and unused codes always finish with done
            end
        endcase
    end

    // byte store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[tail_reg] <= data_reg[7:0];
        end
        if (issue)
        begin
            q_reg <= ring_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            op_reg         <= OP_PUSH;
            len_reg        <= '0;
            data_reg       <= '0;
            total_reg      <= '0;
            iss_reg        <= '0;
            pos_reg        <= '0;
            dvalid_reg     <= 1'b0;
            rd_addr_reg    <= '0;
            res_status_reg <= ST_DONE;
            res_word_reg   <= '0;
            res_offset_reg <= '0;
            res_moved_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_word_reg   <= '0;
            out_offset_reg <= '0;
            out_moved_reg  <= '0;
            out_fill_reg   <= '0;
        end
        else
        begin
            // result register drains when taken, unless refilled in this cycle
            if (out_valid_reg && result.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg         <= op_in;
                        len_reg        <= n_in;
                        data_reg       <= request.data_word;
                        iss_reg        <= '0;
                        pos_reg        <= '0;
                        dvalid_reg     <= 1'b0;
                        rd_addr_reg    <= head_reg;
                        res_status_reg <= start_status;
                        res_word_reg   <= '0;
                        res_offset_reg <= '0;
                        res_moved_reg  <= start_moved;
                        state_reg      <= start_state;
                        // seek walks every stored byte, the others their count
                        total_reg      <= (op_in == OP_SEEK) ? occ_reg : n_ext;
                        case (op_in)
                            OP_DISCARD:
                            begin
                                if (skip_ok)
                                begin
                                    head_reg <= IDX_W'(skip_head);
                                    occ_reg  <= occ_reg - OCC_W'(request.skip_count);
                                end
                            end
                            OP_CLEAR:
                            begin
                                head_reg <= '0;
                                tail_reg <= '0;
                                occ_reg  <= '0;
                            end
                            default:
                            begin
                                // push and pop move the pointers in later steps, the other codes leave them
                            end
                        endcase
                    end
                end

                S_PUSH:
                begin
                    // one byte into the store per cycle
                    tail_reg <= (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    data_reg <= data_reg >> 8;
                    iss_reg  <= iss_reg + 1'b1;
                    if (iss_reg + 1'b1 == total_reg)
                    begin
                        occ_reg   <= occ_reg + total_reg;
                        state_reg <= S_FINISH;
                    end
                end

                S_READ:
                begin
                    dvalid_reg <= issue;
                    if (issue)
                    begin
                        rd_addr_reg <= (rd_addr_reg == IDX_W'(DEPTH - 1)) ?
                                       '0 : rd_addr_reg + 1'b1;
                        iss_reg     <= iss_reg + 1'b1;
                    end
                    if (dvalid_reg)
                    begin
                        pos_reg <= pos_inc;
                        if (op_reg == OP_SEEK)
                        begin
                            // window holds enough bytes once pos + 1 reaches the length
                            if (hit && (pos_inc >= OCC_W'(len_reg)))
                            begin
                                res_status_reg <= ST_DONE;
                                res_offset_reg <= OFFSET_W'(pos_inc - OCC_W'(len_reg));
                                state_reg      <= S_FINISH;
                            end
                            else if (pos_inc == total_reg)
                            begin
                                state_reg <= S_FINISH;
                            end
                        end
                        else
                        begin
                            res_word_reg[{pos_reg[2:0], 3'b000} +: 8] <= q_reg;
                            if (pos_inc == total_reg)
                            begin
                                // all reads issued, so the read address is the new head
                                if (op_reg == OP_POP)
                                begin
                                    head_reg <= rd_addr_reg;
                                    occ_reg  <= occ_reg - total_reg;
                                end
                                state_reg <= S_FINISH;
                            end
                        end
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_word_reg   <= res_word_reg;
                        out_offset_reg <= res_offset_reg;
                        out_moved_reg  <= res_moved_reg;
                        out_fill_reg   <= FILL_W'(occ_reg);
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- tb/byte_ring_fifo_with_pattern_seek_tb.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_pattern_seek_tb
// self-checking bench for the byte ring fifo with pattern seek
// ----------------------------------------------------------------------------
// requests go in through the request channel with random gaps, results come
// back through the result channel with random stalls. a shadow fifo inside
// the bench predicts every result at the moment its request is accepted, and
// each result that comes back is compared field by field with the oldest
// prediction. the run covers corner cases on an empty and a small fifo, a
// complete fill with wrap of both indices, and a long random mix of all
// operations including unused operation codes.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_pattern_seek_tb;

    import brf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int FULL_XFER   = MAX_XFER_DEF;
    localparam int RANDOM_REQS = 550;
    // watchdog limit, kept with a wide margin over the slowest run of this stimulus
    localparam int CYCLE_LIMIT = 600000;

    // one result as the block reports it
    typedef struct packed {
        status_t             status;
        logic [WORD_W-1:0]   read_word;
        logic [OFFSET_W-1:0] match_offset;
        logic [MOVED_W-1:0]  moved_count;
        logic [FILL_W-1:0]   fill_level;
    } fifo_result_t;

    logic clk;
    logic rst_n;

    brf_req_if request_ch ();
    brf_rsp_if result_ch ();

    byte_ring_fifo_with_pattern_seek dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    // shadow copy of the fifo, updated as each request is accepted
    logic [7:0] shadow_ring [DEPTH];
    int         shadow_head;
    int         shadow_tail;
    int         shadow_fill;

    // predicted results in request order, oldest first
    fifo_result_t awaited_results [$];
    fifo_result_t oldest_expected;

    int error_count;
    int cycle_count;

    // idle control for both sides, set by the test tasks
    bit send_no_gap;
    bit recv_no_stall;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // shadow fifo helpers
    // ------------------------------------------------------------------
    function automatic int ring_slot(int pos);
        return pos % DEPTH;
    endfunction

    // n stored bytes starting ofs bytes past the head, first byte lowest
    function automatic logic [WORD_W-1:0] shadow_bytes_at(int ofs, int n);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < n; i++)
            w[8*i +: 8] = shadow_ring[ring_slot(shadow_head + ofs + i)];
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // bytes from a tiny alphabet so patterns repeat and partly match
    function automatic logic [WORD_W-1:0] sparse_word();
        logic [WORD_W-1:0] w;
        for (int b = 0; b < 8; b++)
            w[8*b +: 8] = 8'($urandom_range(0, 2));
        return w;
    endfunction

    // applies one accepted request to the shadow fifo and returns its result
    function automatic fifo_result_t predict_fifo_result(
        logic [OP_W-1:0]    op,
        logic [COUNT_W-1:0] count,
        logic [WORD_W-1:0]  data,
        logic [SKIP_W-1:0]  skip
    );
        fifo_result_t r;
        int           n;
        bit           hit;
        r = '0;
        r.status = ST_DONE;
        // counts above the transfer size saturate
        n = (int'(count) > FULL_XFER) ? FULL_XFER : int'(count);
        case (op)
            OP_PUSH:
            begin
                if (n > DEPTH - shadow_fill)
                    r.status = ST_NO_SPACE;
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        shadow_ring[shadow_tail] = data[8*i +: 8];
                        shadow_tail = ring_slot(shadow_tail + 1);
                    end
                    shadow_fill += n;
                    r.moved_count = MOVED_W'(n);
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (n > shadow_fill)
                    r.status = ST_NO_DATA;
                else
                begin
                    r.read_word = shadow_bytes_at(0, n);
                    r.moved_count = MOVED_W'(n);
                    if (op == OP_POP)
                    begin
                        shadow_head = ring_slot(shadow_head + n);
                        shadow_fill -= n;
                    end
                end
            end
            OP_SEEK:
            begin
                // an empty pattern hits at the head, even on an empty fifo
                r.status = ST_NO_DATA;
                if (n <= shadow_fill)
                begin
                    for (int i = 0; i + n <= shadow_fill; i++)
                    begin
                        hit = 1'b1;
                        for (int j = 0; j < n; j++)
                            if (shadow_ring[ring_slot(shadow_head + i + j)] != data[8*j +: 8])
                                hit = 1'b0;
                        if (hit)
                        begin
                            r.status = ST_DONE;
                            r.match_offset = OFFSET_W'(i);
                            break;
                        end
                    end
                end
            end
            OP_DISCARD:
            begin
                if (int'(skip) > shadow_fill)
                    r.status = ST_NO_DATA;
                else
                begin
                    shadow_head = ring_slot(shadow_head + int'(skip));
                    shadow_fill -= int'(skip);
                    r.moved_count = MOVED_W'(skip);
                end
            end
            OP_CLEAR:
            begin
                // stale bytes stay in the shadow ring but are never read again
                shadow_head = 0;
                shadow_tail = 0;
                shadow_fill = 0;
            end
            default:
            begin
                // unused codes leave the fifo alone
            end
        endcase
        r.fill_level = FILL_W'(shadow_fill);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // drives one request at the falling edge and waits for it to be taken;
    // valid stays high afterwards so a back-to-back request has no gap
    task automatic send_request(int op, int count, logic [WORD_W-1:0] data, int skip);
        int gap;
        gap = send_no_gap ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            request_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request_ch.operation  = OP_W'(op);
        request_ch.byte_count = COUNT_W'(count);
        request_ch.data_word  = data;
        request_ch.skip_count = SKIP_W'(skip);
        request_ch.valid      = 1'b1;
        do
            @(posedge clk);
        while (request_ch.ready !== 1'b1);
        awaited_results.push_back(predict_fifo_result(request_ch.operation,
            request_ch.byte_count, request_ch.data_word, request_ch.skip_count));
    endtask

    // holds off new requests until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        request_ch.valid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side: random stall before each result, then wait for it
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        forever
        begin
            stall = recv_no_stall ? 0 : $urandom_range(0, 10);
            repeat (stall)
            begin
                @(negedge clk);
                result_ch.ready = 1'b0;
            end
            @(negedge clk);
            result_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no request pending: status %0d, fill_level %0d",
                       result_ch.status, result_ch.fill_level);
                error_count++;
            end
            else
            begin
                oldest_expected = awaited_results.pop_front();
                if (result_ch.status !== oldest_expected.status)
                begin
                    $error("status: expected %0d, got %0d",
                           oldest_expected.status, result_ch.status);
                    error_count++;
                end
                if (result_ch.read_word !== oldest_expected.read_word)
                begin
                    $error("read_word: expected %h, got %h",
                           oldest_expected.read_word, result_ch.read_word);
                    error_count++;
                end
                if (result_ch.match_offset !== oldest_expected.match_offset)
                begin
                    $error("match_offset: expected %0d, got %0d",
                           oldest_expected.match_offset, result_ch.match_offset);
                    error_count++;
                end
                if (result_ch.moved_count !== oldest_expected.moved_count)
                begin
                    $error("moved_count: expected %0d, got %0d",
                           oldest_expected.moved_count, result_ch.moved_count);
                    error_count++;
                end
                if (result_ch.fill_level !== oldest_expected.fill_level)
                begin
                    $error("fill_level: expected %0d, got %0d",
                           oldest_expected.fill_level, result_ch.fill_level);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------
    // empty fifo, zero counts, saturated counts, empty pattern, match at the
    // last position, junk above the pattern, unused codes and clear
    task automatic test_corner_cases();
        send_request(OP_POP, 1, 64'h0, 0);                      // no data
        send_request(OP_PEEK, 0, random_word(), 0);             // zero count
        send_request(OP_POP, 0, 64'h0, 0);
        send_request(OP_SEEK, 0, random_word(), 0);             // empty pattern, empty fifo
        send_request(OP_SEEK, 1, 64'h0, 0);                     // pattern longer than data
        send_request(OP_DISCARD, 0, 64'h0, 0);
        send_request(OP_DISCARD, 1, 64'h0, 1);                  // discard beyond data
        send_request(OP_PUSH, 0, random_word(), 0);
        send_request(OP_PUSH, 15, 64'h0706_0504_0302_0100, 0);  // saturates to eight
        send_request(OP_PUSH, 8, 64'hFFFF_FFFF_FFFF_FFFF, 8191);
        send_request(OP_PEEK, 12, 64'h0, 0);
        send_request(OP_SEEK, 3, 64'h0000_0000_0005_0403, 0);
        send_request(OP_SEEK, 9, 64'hFFFF_FFFF_FFFF_FFFF, 0);   // last possible position
        send_request(OP_SEEK, 2, 64'hDEAD_BEEF_0000_0504, 0);   // junk above the pattern
        send_request(OP_SEEK, 2, 64'h0000_0000_0000_0607, 0);   // no match
        send_request(OP_POP, 3, 64'h0, 0);
        send_request(OP_PUSH, 2, 64'hA5A5_A5A5_A5A5_1234, 0);
        send_request(6, 8, random_word(), 4096);
        send_request(7, 15, random_word(), 8191);
        send_request(OP_DISCARD, 0, 64'h0, 4);
        send_request(OP_DISCARD, 0, 64'h0, 8191);
        send_request(OP_CLEAR, 8, random_word(), 8191);
        send_request(OP_POP, 1, 64'h0, 0);
        send_request(OP_PUSH, 8, 64'h0, 0);
        send_request(OP_POP, 8, 64'h0, 0);
    endtask

    // fills the fifo to the brim, then leaves the head just short of the end
    // of the ring so that later traffic wraps both indices
    task automatic test_full_capacity();
        int last;
        last = DEPTH / FULL_XFER - 1;
        send_request(OP_CLEAR, 0, 64'h0, 0);
        for (int k = 0; k <= last; k++)
            send_request(OP_PUSH, FULL_XFER,
                         (k % 4 == 0 || k == last) ? random_word() : sparse_word(), 0);
        send_request(OP_PUSH, 1, random_word(), 0);             // no space
        send_request(OP_PUSH, 0, random_word(), 0);             // fits even when full
        send_request(OP_PUSH, 15, random_word(), 0);
        drain_results();
        send_request(OP_PEEK, FULL_XFER, 64'h0, 0);
        send_request(OP_SEEK, FULL_XFER, shadow_bytes_at(DEPTH - FULL_XFER, FULL_XFER), 0);
        send_request(OP_SEEK, FULL_XFER, random_word(), 0);     // walks the whole store
        send_request(OP_DISCARD, 0, 64'h0, 8191);
        send_request(OP_DISCARD, 0, 64'h0, DEPTH + 1);
        send_request(OP_DISCARD, 0, 64'h0, DEPTH - 6);
        send_request(OP_PEEK, FULL_XFER, 64'h0, 0);             // only six bytes left
        send_request(OP_PUSH, FULL_XFER, random_word(), 0);
        send_request(OP_PEEK, FULL_XFER, 64'h0, 0);             // spans the ring end
        send_request(OP_SEEK, 6, shadow_bytes_at(3, 6), 0);
        send_request(OP_DISCARD, 0, 64'h0, DEPTH);              // too much
        send_request(OP_POP, 3, 64'h0, 0);
    endtask

    // random mix of all operations, weighted so that pops, peeks and seeks
    // mostly find data and seeks mostly find a pattern taken from the store
    task automatic test_random_mix(int total);
        int                pick;
        int                n;
        int                ofs;
        int                top;
        int                skip;
        logic [WORD_W-1:0] w;
        for (int k = 0; k < total; k++)
        begin
            // alternate spells of idling and full-rate traffic on each side
            send_no_gap   = ((k / 64) % 2 == 1);
            recv_no_stall = ((k / 96) % 2 == 1);
            if (k % 150 == 149)
                drain_results();
            pick = $urandom_range(0, 99);
            // keep the fill moderate so seek walks stay short
            if (pick < 35 && shadow_fill > 200)
                pick = 40;
            if (pick < 35)
            begin
                w = ($urandom_range(0, 1) == 1) ? random_word() : sparse_word();
                send_request(OP_PUSH, $urandom_range(0, 15), w, $urandom_range(0, 8191));
            end
            else if (pick < 55)
                send_request(OP_POP, $urandom_range(0, 15), random_word(),
                             $urandom_range(0, 8191));
            else if (pick < 65)
                send_request(OP_PEEK, $urandom_range(0, 15), random_word(),
                             $urandom_range(0, 8191));
            else if (pick < 80)
            begin
                if (shadow_fill > 0 && $urandom_range(0, 9) < 7)
                begin
                    // pattern copied from somewhere in the stored bytes
                    ofs = $urandom_range(0, shadow_fill - 1);
                    top = (shadow_fill - ofs > FULL_XFER) ? FULL_XFER : shadow_fill - ofs;
                    n = $urandom_range(0, top);
                    w = shadow_bytes_at(ofs, n);
                    if (n < FULL_XFER && $urandom_range(0, 1) == 1)
                        w = w | (random_word() & ~((64'd1 << (8 * n)) - 64'd1));
                    send_request(OP_SEEK, (n == FULL_XFER) ? $urandom_range(8, 15) : n, w,
                                 $urandom_range(0, 8191));
                end
                else
                    send_request(OP_SEEK, $urandom_range(0, 15), sparse_word(),
                                 $urandom_range(0, 8191));
            end
            else if (pick < 92)
            begin
                top = $urandom_range(0, 9);
                if (top < 6)
                    skip = $urandom_range(0, (shadow_fill < 24) ? shadow_fill : 24);
                else if (top < 7)
                    skip = shadow_fill;
                else if (top < 9)
                    skip = shadow_fill + $urandom_range(1, 16);
                else
                    skip = $urandom_range(0, 8191);
                send_request(OP_DISCARD, $urandom_range(0, 15), random_word(), skip);
            end
            else if (pick < 94)
                send_request(OP_CLEAR, $urandom_range(0, 15), random_word(),
                             $urandom_range(0, 8191));
            else
                send_request($urandom_range(6, 7), $urandom_range(0, 15), random_word(),
                             $urandom_range(0, 8191));
        end
        send_no_gap   = 1'b0;
        recv_no_stall = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        error_count   = 0;
        send_no_gap   = 1'b0;
        recv_no_stall = 1'b0;
        shadow_head   = 0;
        shadow_tail   = 0;
        shadow_fill   = 0;

        request_ch.valid      = 1'b0;
        request_ch.operation  = '0;
        request_ch.byte_count = '0;
        request_ch.data_word  = '0;
        request_ch.skip_count = '0;

        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_corner_cases();
        drain_results();
        test_full_capacity();
        drain_results();
        test_random_mix(RANDOM_REQS);

        // let the last results come back, then watch for strays
        drain_results();
        repeat (16) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- byte_ring_fifo_with_pattern_seek.f -----
src/brf_pkg.sv
src/brf_if.sv
src/brf_match.sv
src/byte_ring_fifo_with_pattern_seek.sv
tb/byte_ring_fifo_with_pattern_seek_tb.sv
